@@ rtl/kct_pkg.sv @@
// Package for the keyed count table: result status codes, field widths and
// the default table depth. No dependencies.
package kct_pkg;

    localparam int KCT_ENTRIES = 128;

    localparam int KEY_W    = 32;
    localparam int AMOUNT_W = 16;
    localparam int COUNT_W  = 32;
    localparam int INDEX_W  = 7;
    localparam int STATUS_W = 3;

    localparam logic [STATUS_W-1:0] STAT_ADDED    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NEW      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_REMOVED  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_SHORT    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd5;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

endpackage

@@ rtl/keyed_count_table.sv @@
// Keyed count table top level: a key/count memory searched in entry order.
// Depends on kct_pkg.
//
// The block takes one transfer at a time and answers each with exactly one
// result transfer. Keys and counts share one synchronous memory of ENTRIES
// words with a registered read; a request reads the entries in use one per
// cycle, starting at entry 0, until the first matching key, then updates the
// count and loads the result register in the update state. The next transfer
// can be taken in the cycle after the result is loaded. A finished result
// waits in the output register while the next request is accepted and
// searched; the update waits only if that register is still full. Adds
// saturate at the maximum count; an add to a full table and a remove of a
// missing key report with index and count 0.
module keyed_count_table
#(
    parameter int ENTRIES = kct_pkg::KCT_ENTRIES
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [kct_pkg::KEY_W-1:0]     key,
    input  logic [kct_pkg::AMOUNT_W-1:0]  amount,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [kct_pkg::STATUS_W-1:0]  status,
    output logic [kct_pkg::INDEX_W-1:0]   entry_index,
    output logic [kct_pkg::COUNT_W-1:0]   count_after
);
    import kct_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int USED_W = $clog2(ENTRIES + 1);
    localparam int WORD_W = KEY_W + COUNT_W;

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic [USED_W-1:0]   ptr_reg, ptr_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic                hit_reg, hit_next;
    logic                out_valid_reg, out_valid_next;

    logic                cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [AMOUNT_W-1:0] amt_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    logic [WORD_W-1:0]   mem [ENTRIES];
    logic [WORD_W-1:0]   rd_data_reg;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [WORD_W-1:0]   wr_data;

    logic [KEY_W-1:0]    rd_key;
    logic [COUNT_W-1:0]  rd_cnt;
    logic [COUNT_W:0]    sum;
    logic [COUNT_W-1:0]  sum_sat;
    logic [COUNT_W-1:0]  amt_ext;
    logic                accept;
    logic                out_take;
    logic                out_free;
    logic                full;

    assign rd_key   = rd_data_reg[WORD_W-1:COUNT_W];
    assign rd_cnt   = rd_data_reg[COUNT_W-1:0];
    assign amt_ext  = COUNT_W'(amt_reg);
    assign sum      = {1'b0, rd_cnt} + {1'b0, amt_ext};
    assign sum_sat  = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
    assign full     = (used_reg == USED_W'(ENTRIES));

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        ptr_next       = ptr_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        hit_next       = hit_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        status_next    = status_reg;
        index_next     = index_reg;
        count_next     = count_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = pidx_reg;
        wr_data        = {key_reg, rd_cnt};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SEARCH;
                    ptr_next   = '0;
                    hit_next   = 1'b0;
                end
            end
            ST_SEARCH:
            begin
                if (pend_reg && (rd_key == key_reg))
                begin
                    hit_next   = 1'b1;
                    state_next = ST_UPDATE;
                end
                else if (ptr_reg < used_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[IDX_W-1:0];
                    ptr_next  = ptr_reg + 1'b1;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (cmd_reg == CMD_ADD)
                    begin
                        if (hit_reg)
                        begin
                            wr_en       = 1'b1;
                            wr_data     = {key_reg, sum_sat};
                            status_next = STAT_ADDED;
                            index_next  = INDEX_W'(pidx_reg);
                            count_next  = sum_sat;
                        end
                        else if (!full)
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = used_reg[IDX_W-1:0];
                            wr_data     = {key_reg, amt_ext};
                            used_next   = used_reg + 1'b1;
                            status_next = STAT_NEW;
                            index_next  = INDEX_W'(used_reg[IDX_W-1:0]);
                            count_next  = amt_ext;
                        end
                        else
                        begin
                            status_next = STAT_FULL;
                            index_next  = '0;
                            count_next  = '0;
                        end
                    end
                    else
                    begin
                        if (hit_reg && (rd_cnt >= amt_ext))
                        begin
                            wr_en       = 1'b1;
                            wr_data     = {key_reg, rd_cnt - amt_ext};
                            status_next = STAT_REMOVED;
                            index_next  = INDEX_W'(pidx_reg);
                            count_next  = rd_cnt - amt_ext;
                        end
                        else if (hit_reg)
                        begin
                            status_next = STAT_SHORT;
                            index_next  = INDEX_W'(pidx_reg);
                            count_next  = rd_cnt;
                        end
                        else
                        begin
                            status_next = STAT_NOTFOUND;
                            index_next  = '0;
                            count_next  = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg   <= pidx_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        count_reg  <= count_next;
        if (accept)
        begin
            cmd_reg <= command;
            key_reg <= key;
            amt_reg <= amount;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_index = index_reg;
    assign count_after = count_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(ENTRIES))
        else $error("Entry count exceeds the table depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("Memory write and search read in the same cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_UPDATE))
        else $error("Result appeared without an update cycle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) && out_free |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("Update cycle did not deliver its result.");
`endif

endmodule

@@ tb/keyed_count_table_tb.sv @@
// Self-checking testbench for keyed_count_table: directed and random traffic
// under varied valid/stall idling, checked against a scoreboard class.
// Depends on kct_pkg and the keyed_count_table RTL.
`timescale 1ns / 100ps

module keyed_count_table_tb;
    import kct_pkg::*;

    localparam int STALL_LIMIT      = 5000;
    localparam int HOLD_CYCLES      = 300;
    localparam int TAIL_CYCLES      = 150;
    localparam int RANDOM_PER_PHASE = 100;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [COUNT_W-1:0]  count;
    } table_result_t;

    class count_table_scoreboard;
        logic [KEY_W-1:0]   key_tab [KCT_ENTRIES];
        logic [COUNT_W-1:0] count_tab [KCT_ENTRIES];
        int unsigned        used_count;
        table_result_t      awaited_results [$];
        int unsigned        mismatches;
        int unsigned        requests;
        int unsigned        status_hits [8];

        function new();
            used_count = 0;
            mismatches = 0;
            requests = 0;
            foreach (status_hits[i])
                status_hits[i] = 0;
        endfunction

        function void note_request(input logic cmd, input logic [KEY_W-1:0] k,
                                   input logic [AMOUNT_W-1:0] amt);
            table_result_t r;
            int hit;
            logic [COUNT_W:0] sum;
            hit = -1;
            for (int i = 0; i < int'(used_count); i++)
            begin
                if (hit < 0 && key_tab[i] == k)
                    hit = i;
            end
            r = '0;
            if (cmd == CMD_ADD)
            begin
                if (hit >= 0)
                begin
                    sum = {1'b0, count_tab[hit]} + amt;
                    count_tab[hit] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
                    r.status = STAT_ADDED;
                    r.index = INDEX_W'(hit);
                    r.count = count_tab[hit];
                end
                else if (used_count < KCT_ENTRIES)
                begin
                    key_tab[used_count] = k;
                    count_tab[used_count] = COUNT_W'(amt);
                    r.status = STAT_NEW;
                    r.index = INDEX_W'(used_count);
                    r.count = COUNT_W'(amt);
                    used_count++;
                end
                else
                    r.status = STAT_FULL;
            end
            else if (hit >= 0)
            begin
                if (count_tab[hit] >= amt)
                begin
                    count_tab[hit] = count_tab[hit] - amt;
                    r.status = STAT_REMOVED;
                end
                else
                    r.status = STAT_SHORT;
                r.index = INDEX_W'(hit);
                r.count = count_tab[hit];
            end
            else
                r.status = STAT_NOTFOUND;
            requests++;
            status_hits[r.status]++;
            awaited_results.push_back(r);
        endfunction

        task report(input string what, input logic [COUNT_W-1:0] got,
                    input logic [COUNT_W-1:0] want);
            $display("mismatch at %0t: %s, got %0h, want %0h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_result(input logic [STATUS_W-1:0] st, input logic [INDEX_W-1:0] idx,
                          input logic [COUNT_W-1:0] cnt);
            table_result_t want;
            if (awaited_results.size() == 0)
            begin
                report("result with no request pending", cnt, '0);
                return;
            end
            want = awaited_results.pop_front();
            if (st !== want.status)
                report("status", COUNT_W'(st), COUNT_W'(want.status));
            if (idx !== want.index)
                report("entry_index", COUNT_W'(idx), COUNT_W'(want.index));
            if (cnt !== want.count)
                report("count_after", cnt, want.count);
        endtask
    endclass

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                command = CMD_ADD;
    logic [KEY_W-1:0]    key = '0;
    logic [AMOUNT_W-1:0] amount = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  entry_index;
    logic [COUNT_W-1:0]  count_after;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit pressure_on = 1'b0;
    bit pressure_done = 1'b0;
    int quiet_cycles = 0;

    count_table_scoreboard sb = new();

    keyed_count_table dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .key         (key),
        .amount      (amount),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_index (entry_index),
        .count_after (count_after)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Called at a rising edge; returns at the rising edge that takes the transfer.
    task automatic send_request(input logic cmd, input logic [KEY_W-1:0] k,
                                input logic [AMOUNT_W-1:0] amt);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        key <= k;
        amount <= amt;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            if (taken)
                sb.note_request(cmd, k, amt);
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic send_random_request();
        int sel;
        int idx;
        logic cmd;
        logic [KEY_W-1:0] k;
        logic [AMOUNT_W-1:0] amt;
        logic [AMOUNT_W-1:0] lim;
        logic [COUNT_W-1:0] cnt;
        sel = $urandom_range(99);
        cmd = CMD_ADD;
        k = $urandom;
        amt = AMOUNT_W'($urandom);
        if (sel >= 40 && sb.used_count != 0)
        begin
            cmd = logic'($urandom_range(1));
            if (sel < 85)
            begin
                idx = $urandom_range(sb.used_count - 1);
                k = sb.key_tab[idx];
                cnt = sb.count_tab[idx];
                lim = (cnt > COUNT_W'(16'hFFFF)) ? 16'hFFFF : cnt[AMOUNT_W-1:0];
                case ($urandom_range(2))
                    0: amt = lim;
                    1: amt = AMOUNT_W'($urandom_range(lim));
                    default: amt = AMOUNT_W'($urandom);
                endcase
            end
        end
        send_request(cmd, k, amt);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input bit pressure);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        pressure_on = pressure;
        repeat (RANDOM_PER_PHASE)
            send_random_request();
        drain_results();
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (pressure_on && !pressure_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                pressure_done = 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if (out_valid && !out_stall)
                sb.check_result(status, entry_index, count_after);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(CMD_REMOVE, 32'h0000_0000, 16'h0000);
        send_request(CMD_ADD,    32'h0000_0000, 16'h0000);
        send_request(CMD_ADD,    32'hFFFF_FFFF, 16'hFFFF);
        send_request(CMD_ADD,    32'h0000_0000, 16'hFFFF);
        send_request(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(CMD_REMOVE, 32'hFFFF_FFFF, 16'h0001);
        send_request(CMD_REMOVE, 32'h0000_0000, 16'h0000);
        send_request(CMD_REMOVE, 32'h0000_0000, 16'hFFFF);
        send_request(CMD_ADD,    32'hA5A5_A5A5, 16'h5A5A);
        send_request(CMD_ADD,    32'h5A5A_5A5A, 16'hA5A5);
        send_request(CMD_REMOVE, 32'h1234_5678, 16'h0001);
        send_request(CMD_ADD,    32'hFFFF_FFFE, 16'h0001);
        send_request(CMD_REMOVE, 32'hFFFF_FFFE, 16'h0002);
        send_request(CMD_ADD,    32'h0000_0001, 16'h8000);
        send_request(CMD_ADD,    32'h0000_0001, 16'h7FFF);
        send_request(CMD_REMOVE, 32'h0000_0001, 16'hFFFF);
        send_request(CMD_REMOVE, 32'h0000_0001, 16'h0000);
        send_request(CMD_REMOVE, 32'h5A5A_5A5A, 16'hA5A6);
        send_request(CMD_REMOVE, 32'hA5A5_A5A5, 16'h5A5A);
        drain_results();

        run_phase(0, 0, 1'b0);
        run_phase(84, 0, 1'b0);
        run_phase(0, 84, 1'b1);
        run_phase(9, 9, 1'b0);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.awaited_results.size() != 0)
            sb.report("requests left unanswered", sb.awaited_results.size(), '0);

        $display("covered %0d requests over directed, random and back-pressure runs",
                 sb.requests);
        $display("outcomes: new %0d, added %0d, full %0d, removed %0d, short %0d, missing %0d",
                 sb.status_hits[STAT_NEW], sb.status_hits[STAT_ADDED],
                 sb.status_hits[STAT_FULL], sb.status_hits[STAT_REMOVED],
                 sb.status_hits[STAT_SHORT], sb.status_hits[STAT_NOTFOUND]);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/kct_pkg.sv
rtl/keyed_count_table.sv
tb/keyed_count_table_tb.sv
